// ----- design/prs80_pkg.sv -----
// ----------------------------------------------------------------------------
// prs80_pkg
// Shared types, constants and round functions for the PRESENT-80 encryptor.
// ----------------------------------------------------------------------------
package prs80_pkg;

  localparam int unsigned BLOCK_W  = 64;
  localparam int unsigned KEY_W    = 80;
  localparam int unsigned KEY_HI_W = 16;
  localparam int unsigned ROUNDS   = 31;
  localparam int unsigned RC_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [RC_W-1:0]    rc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } cfg_reg_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0:    y = 4'hC;
      4'h1:    y = 4'h5;
      4'h2:    y = 4'h6;
      4'h3:    y = 4'hB;
      4'h4:    y = 4'h9;
      4'h5:    y = 4'h0;
      4'h6:    y = 4'hA;
      4'h7:    y = 4'hD;
      4'h8:    y = 4'h3;
      4'h9:    y = 4'hE;
      4'hA:    y = 4'hF;
      4'hB:    y = 4'h8;
      4'hC:    y = 4'h4;
      4'hD:    y = 4'h7;
      4'hE:    y = 4'h1;
      4'hF:    y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic block_t sub_cells(input block_t s);
    block_t r;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i moves to bit i/4 + 16*(i%4)
  function automatic block_t perm_layer(input block_t s);
    block_t r;
    for (int i = 0; i < BLOCK_W; i++) begin
      r[(i / 4) + (i % 4) * 16] = s[i];
    end
    return r;
  endfunction

  function automatic block_t subkey(input key_t k);
    return k[KEY_W-1 -: BLOCK_W];
  endfunction

  function automatic key_t key_update(input key_t k, input rc_t rc);
    key_t r;
    r = {k[18:0], k[KEY_W-1:19]};
    r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
    r[19:15] = r[19:15] ^ rc;
    return r;
  endfunction

endpackage

// ----- design/prs80_round_cell.sv -----
// ----------------------------------------------------------------------------
// prs80_round_cell
// One registered PRESENT round: key add, S-box layer, permutation, key update.
// ----------------------------------------------------------------------------
module prs80_round_cell #(
  parameter prs80_pkg::rc_t RC = prs80_pkg::rc_t'(1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  prs80_pkg::block_t   state_in,
  input  prs80_pkg::key_t     key_in,
  output logic                vld_out,
  output prs80_pkg::block_t   state_out,
  output prs80_pkg::key_t     key_out
);

  logic              vld_r;
  prs80_pkg::block_t state_r, state_nxt;
  prs80_pkg::key_t   key_r, key_nxt;

  always_comb begin
    state_nxt = prs80_pkg::perm_layer(
                  prs80_pkg::sub_cells(state_in ^ prs80_pkg::subkey(key_in)));
    key_nxt   = prs80_pkg::key_update(key_in, RC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  assign vld_out   = vld_r;
  assign state_out = state_r;
  assign key_out   = key_r;

endmodule

// ----- design/prs80_out_buf.sv -----
// ----------------------------------------------------------------------------
// prs80_out_buf
// Output register with skid entry; holds the pipeline when both are full.
// ----------------------------------------------------------------------------
module prs80_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  prs80_pkg::block_t up_data,
  output logic              up_ready,
  output logic              dn_valid,
  output prs80_pkg::block_t dn_data,
  input  logic              dn_ready
);

  logic              out_vld_r;
  prs80_pkg::block_t out_data_r;
  logic              skid_vld_r;
  prs80_pkg::block_t skid_data_r;
  logic              push;
  logic              out_free;

  assign up_ready = !skid_vld_r;
  assign push     = up_valid && up_ready;
  assign out_free = !out_vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_vld_r ? skid_data_r : up_data;
    end else if (push) begin
      skid_data_r <= up_data;
    end
  end

  assign dn_valid = out_vld_r;
  assign dn_data  = out_data_r;

endmodule

// ----- design/present80_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// present80_block_encrypt_top
// PRESENT-80 encryptor: a chain of 31 registered round cells, each carrying
// its block and key schedule to the next, then final key add and output buffer.
//
//   channel  ports                          direction
//   in       in_valid/in_ready/in_plaintext  item in, 64-bit block
//   out      out_valid/out_ready/out_ciphertext  item out, 64-bit block
//   cfg      cfg_we/cfg_index/cfg_wdata      key register writes
//
// One item per cycle sustained unless out_ready stalls the output buffer;
// items pass 31 round cells and the output register. Reset (rst_n low,
// synchronous) clears all valid bits and the key to zero. The whole chain holds
// while the skid entry is full, so in_ready depends only on registered state.
// ----------------------------------------------------------------------------
module present80_block_encrypt_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [prs80_pkg::BLOCK_W-1:0]       in_plaintext,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [prs80_pkg::BLOCK_W-1:0]       out_ciphertext,
  input  logic                                cfg_we,
  input  logic [prs80_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prs80_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned N = prs80_pkg::ROUNDS;

  logic [prs80_pkg::BLOCK_W-1:0]  key_low_r;
  logic [prs80_pkg::KEY_HI_W-1:0] key_high_r;

  logic              vld   [0:N];
  prs80_pkg::block_t state [0:N];
  prs80_pkg::key_t   key   [0:N];
  logic              en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (prs80_pkg::cfg_reg_t'(cfg_index))
        prs80_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        prs80_pkg::REG_KEY_HIGH: key_high_r <= cfg_wdata[prs80_pkg::KEY_HI_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = en;
  assign vld[0]   = in_valid;
  assign state[0] = in_plaintext;
  assign key[0]   = {key_high_r, key_low_r};

  for (genvar g = 0; g < N; g++) begin : g_cell
    prs80_round_cell #(
      .RC(prs80_pkg::rc_t'(g + 1))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .vld_in   (vld[g]),
      .state_in (state[g]),
      .key_in   (key[g]),
      .vld_out  (vld[g+1]),
      .state_out(state[g+1]),
      .key_out  (key[g+1])
    );
  end

  prs80_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(vld[N]),
    .up_data (state[N] ^ prs80_pkg::subkey(key[N])),
    .up_ready(en),
    .dn_valid(out_valid),
    .dn_data (out_ciphertext),
    .dn_ready(out_ready)
  );

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for present80_block_encrypt_top. A short table of
// directed blocks, some with published PRESENT-80 vectors, then random blocks
// under several keys. Each accepted item's ciphertext is compared with the
// published vector or else with a local model. The sender works in bursts and the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;
  import prs80_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LATENCY     = 32;
  // S-box, nibble n holds S(n)
  localparam logic [63:0] SBOX_TBL = 64'h2174_8FE3_DA09_B65C;

  typedef struct {
    bit     new_key;
    key_t   key;
    block_t pt;
    bit     lit;
    block_t ct;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  block_t                in_plaintext = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  block_t                out_ciphertext;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  block_t      pending_ct[$];
  stim_row_t   dir_rows[$];
  key_t        cur_key = '0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned rx_mode = 0;
  int unsigned rx_hold = 0;
  block_t      exp_ct;

  present80_block_encrypt_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_plaintext   (in_plaintext),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ciphertext (out_ciphertext),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [3:0] sub_nib(input logic [3:0] x);
    return SBOX_TBL[4*x +: 4];
  endfunction

  function automatic block_t present_encrypt(input block_t pt, input key_t key);
    block_t s;
    block_t t;
    key_t   k;
    int     dst;
    s = pt;
    k = key;
    for (int r = 1; r <= ROUNDS; r++) begin
      s = s ^ k[79:16];
      for (int n = 0; n < 16; n++) s[4*n +: 4] = sub_nib(s[4*n +: 4]);
      t = '0;
      for (int i = 0; i < 64; i++) begin
        dst = (i == 63) ? 63 : (i * 16) % 63;
        t[dst] = s[i];
      end
      s = t;
      k = {k[18:0], k[79:19]};
      k[79:76] = sub_nib(k[79:76]);
      k[19:15] = k[19:15] ^ rc_t'(r);
    end
    return s ^ k[79:16];
  endfunction

  function automatic stim_row_t mk_row(input bit nk, input key_t k, input block_t pt,
                                       input bit lit, input block_t ct);
    stim_row_t row;
    row.new_key = nk;
    row.key     = k;
    row.pt      = pt;
    row.lit     = lit;
    row.ct      = ct;
    return row;
  endfunction

  function automatic block_t rand_block();
    block_t b;
    case ($urandom_range(0, 5))
      0:       b = {$urandom(), $urandom()} & {$urandom(), $urandom()}
                   & {$urandom(), $urandom()};
      1:       b = 64'h1 << $urandom_range(0, 63);
      2:       b = ~(64'h1 << $urandom_range(0, 63));
      default: b = {$urandom(), $urandom()};
    endcase
    return b;
  endfunction

  task automatic wait_drained();
    while (pending_ct.size() != 0) @(posedge clk);
  endtask

  // key writes only with the pipeline empty
  task automatic apply_key(input key_t k);
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_wdata <= k[63:0];
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_wdata <= {32'($urandom()), 16'($urandom()), k[79:64]};  // upper bits dropped
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_key = k;
  endtask

  task automatic send_block(input block_t pt, input bit lit, input block_t ct);
    in_valid     <= 1'b1;
    in_plaintext <= pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_ct.push_back(lit ? ct : present_encrypt(pt, cur_key));
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_ct.size() == 0) begin
        errors = errors + 1;
        $display("%0t unexpected item: expected none, actual %h", $time, out_ciphertext);
      end else begin
        exp_ct = pending_ct.pop_front();
        if (out_ciphertext !== exp_ct) begin
          errors = errors + 1;
          $display("%0t ciphertext mismatch: expected %h, actual %h",
                   $time, exp_ct, out_ciphertext);
        end
      end
    end
    if (rx_hold == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_hold <= $urandom_range(30, 200);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= cycle_cnt[3];
    endcase
  end

  initial begin
    key_t k;
    stim_row_t row;
    // key zero, straight out of reset
    dir_rows.push_back(mk_row(0, '0, 64'h0, 1, 64'h5579_C138_7B22_8445));
    dir_rows.push_back(mk_row(0, '0, '1, 1, 64'hA112_FFC7_2F68_417B));
    dir_rows.push_back(mk_row(0, '0, 64'h5555_5555_5555_5555, 0, '0));
    dir_rows.push_back(mk_row(0, '0, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0));
    dir_rows.push_back(mk_row(0, '0, 64'h1, 0, '0));
    dir_rows.push_back(mk_row(0, '0, 64'h8000_0000_0000_0000, 0, '0));
    dir_rows.push_back(mk_row(0, '0, 64'h0123_4567_89AB_CDEF, 0, '0));
    dir_rows.push_back(mk_row(1, '1, 64'h0, 1, 64'hE72C_46C0_F594_5049));
    dir_rows.push_back(mk_row(0, '1, '1, 1, 64'h3333_DCD3_2132_10D2));
    dir_rows.push_back(mk_row(0, '1, 64'h1, 0, '0));
    dir_rows.push_back(mk_row(0, '1, 64'hFFFF_FFFF_0000_0000, 0, '0));
    dir_rows.push_back(mk_row(1, 80'h0123_4567_89AB_CDEF_0123, 64'h0, 0, '0));
    dir_rows.push_back(mk_row(0, 80'h0123_4567_89AB_CDEF_0123, 64'hDEAD_BEEF_CAFE_F00D,
                              0, '0));
    dir_rows.push_back(mk_row(1, {16'h8000, 64'h1}, 64'h0, 0, '0));
    dir_rows.push_back(mk_row(0, {16'h8000, 64'h1}, '1, 0, '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.new_key) apply_key(row.key);
      send_block(row.pt, row.lit, row.ct);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1:       k = '1;
        2:       k = {16'hFFFF, 64'h0};
        3:       k = {16'h0, 64'hFFFF_FFFF_FFFF_FFFF};
        default: k = {16'($urandom()), $urandom(), $urandom()};
      endcase
      apply_key(k);
      gaps_on = (ph != 3);
      burst_left = 0;
      for (int n = 0; n < 75; n++) begin
        if (ph == 4 && n == 37) begin
          in_valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        send_block(rand_block(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
